### hw/rtl/slider_moving_average_level_assert.svh
// Assertion macros for the slider averaging block. Each check is a clocked
// property that is ignored while rst_n is low.
`ifndef SLIDER_MOVING_AVERAGE_LEVEL_ASSERT_SVH
`define SLIDER_MOVING_AVERAGE_LEVEL_ASSERT_SVH

`ifndef SYNTHESIS

`define SMAL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slider average check failed");

`define SMAL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slider average check failed");

`else

`define SMAL_ASSERT_NOW(name, ante, cons)

`define SMAL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### hw/rtl/smal_pkg.sv
`timescale 1ns / 1ps

package smal_pkg;

  // Window length. The average uses a shift, so it must be a power of two.
  localparam int unsigned WINDOW_SIZE = 8;
  localparam int unsigned RING_AW = $clog2(WINDOW_SIZE);

  localparam int unsigned MV_W = 12;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned NUM_BANDS = 8;

  localparam int unsigned FULL_SCALE_MV = 3300;
  localparam int unsigned SUM_W = $clog2(WINDOW_SIZE * FULL_SCALE_MV + 1);

  // Percent is average / 33, done as (average * 1986) >> 16. The rounding
  // error stays below one for every average under 32768.
  localparam int unsigned PCT_SHIFT = 16;
  localparam int unsigned PCT_RECIP_W = 11;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(1986);
  localparam int unsigned PROD_W = MV_W + PCT_RECIP_W;

  typedef logic [MV_W-1:0]    mv_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [RING_AW-1:0] ring_addr_t;

  localparam mv_t FULL_SCALE = MV_W'(FULL_SCALE_MV);

  // Level band starts in millivolts: percent above 1, 15, 29, ... 99 is the
  // same as average at or above 33 times 2, 16, 30, ... 100.
  localparam mv_t LEVEL_MV [NUM_BANDS] = '{
    MV_W'(66),   MV_W'(528),  MV_W'(990),  MV_W'(1452),
    MV_W'(1914), MV_W'(2376), MV_W'(2838), MV_W'(3300)
  };

endpackage

### hw/rtl/slider_moving_average_level.sv
`timescale 1ns / 1ps
// Boxcar moving average of a slider voltage with percent and level outputs.
// Input channel: in_valid, in_sample_mv, in_stall. Output channel: out_valid,
// out_average_mv, out_percent, out_sweep_level, out_stall. A transfer happens
// on a rising edge with valid high and stall low.
// Each input sample is saturated at 3300 mV and replaces the oldest of the
// last eight samples; the block then returns exactly one result.
// The samples sit in an 8-entry synchronous memory: the entry at the ring
// position is read when a sample is accepted; when that sample leaves s1, the
// old entry is subtracted from the running sum, and the new sample is added and written back.
// out_valid rises once the sample has passed s1 and s2 into the result register.
// With no stall the block takes one sample every cycle; each cycle uses one read
// and one write port of the ring.
// After reset the ring reads as all zero (per-entry valid bits), the sum and
// the position are zero, and no result is pending.
// A stall on the output holds the result register; the two stages behind it
// keep filling, and in_stall rises only once they are both occupied.
`include "slider_moving_average_level_assert.svh"

module slider_moving_average_level (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  smal_pkg::mv_t         in_sample_mv,
  output logic                  in_stall,
  output logic                  out_valid,
  output smal_pkg::mv_t         out_average_mv,
  output smal_pkg::pct_t        out_percent,
  output smal_pkg::level_t      out_sweep_level,
  input  logic                  out_stall
);
  import smal_pkg::*;

  mv_t                   ring_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] ring_vld_r;
  mv_t                   rd_data_r;
  logic                  rd_vld_r;

  ring_addr_t pos_r;
  sum_t       sum_r;
  sum_t       sum_nxt;

  logic       s1_valid_r;
  mv_t        s1_sample_r;
  ring_addr_t s1_addr_r;

  logic       s2_valid_r;
  mv_t        s2_avg_r;

  logic       out_valid_r;
  mv_t        out_avg_r;
  pct_t       out_pct_r;
  level_t     out_level_r;

  logic       out_go;
  logic       s2_go;
  logic       s1_go;
  logic       in_fire;
  logic       s1_fire;
  logic       s2_fire;
  mv_t        sample_sat;
  mv_t        old_sample;
  logic [PROD_W-1:0] pct_prod;
  level_t     level_nxt;

  assign out_go  = !out_valid_r || !out_stall;
  assign s2_go   = !s2_valid_r || out_go;
  assign s1_go   = !s1_valid_r || s2_go;
  assign in_stall = !s1_go;
  assign in_fire = in_valid && s1_go;
  assign s1_fire = s1_valid_r && s2_go;
  assign s2_fire = s2_valid_r && out_go;

  assign sample_sat = (in_sample_mv > FULL_SCALE) ? FULL_SCALE : in_sample_mv;

  // An entry is read again only WINDOW_SIZE samples after its write, and at
  // most one older sample is still in flight, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= ring_mem[pos_r];
    end
    if (s1_fire) begin
      ring_mem[s1_addr_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld_r <= ring_vld_r[pos_r];
      end
      if (s1_fire) begin
        ring_vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  assign old_sample = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r <= (pos_r == RING_AW'(WINDOW_SIZE - 1)) ? '0 : pos_r + 1'b1;
      end
      if (s1_fire) begin
        sum_r <= sum_nxt;
      end
      if (s1_go) begin
        s1_valid_r <= in_valid;
      end
      if (s2_go) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_go) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= sample_sat;
      s1_addr_r   <= pos_r;
    end
    if (s1_fire) begin
      s2_avg_r <= MV_W'(sum_nxt >> RING_AW);
    end
    if (s2_fire) begin
      out_avg_r   <= s2_avg_r;
      out_pct_r   <= pct_prod[PCT_SHIFT +: PCT_W];
      out_level_r <= level_nxt;
    end
  end

  assign pct_prod = PROD_W'(s2_avg_r) * PROD_W'(PCT_RECIP);

  // The level counts how many band starts the average has reached.
  always_comb begin
    level_nxt = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (s2_avg_r >= LEVEL_MV[i]) begin
        level_nxt = level_nxt + 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average_mv  = out_avg_r;
  assign out_percent     = out_pct_r;
  assign out_sweep_level = out_level_r;

  `SMAL_ASSERT_NOW(a_rw_addr_differs, in_fire && s1_fire, pos_r != s1_addr_r)
  `SMAL_ASSERT_NOW(a_sum_in_range, 1'b1, sum_r <= SUM_W'(WINDOW_SIZE * FULL_SCALE_MV))
  `SMAL_ASSERT_NEXT(a_accept_fills_s1, in_fire, s1_valid_r)
  `SMAL_ASSERT_NOW(a_percent_in_range, out_valid_r, out_pct_r <= PCT_W'(100))

endmodule
